FILE: hdl/bsn_pkg.sv
// Shared types and constants of the board slot number table.
// No dependencies; every other file refers to it by scoped names.
package bsn_pkg;

  localparam int MAX_CARDS = 16;
  localparam int DOM_W     = 16;
  localparam int BUS_W     = 8;
  localparam int DEV_W     = 5;
  localparam int FUNC_W    = 3;
  localparam int KEY_W     = DOM_W + BUS_W + DEV_W;
  localparam int MASK_W    = 1 << FUNC_W;
  localparam int CARD_W    = 4;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = $clog2(MAX_CARDS + 1);

  localparam logic OP_ATTACH  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  // Request token as it travels down the row of cells
  typedef struct packed {
    logic              done;
    logic              opcode;
    logic [KEY_W-1:0]  key;
    logic [FUNC_W-1:0] func;
    status_e           status;
    logic [CARD_W-1:0] card;
  } tok_t;

endpackage

FILE: hdl/bsn_req_if.sv
// Request channel of the board slot number table: valid, ready and request fields.
// Depends on bsn_pkg for field widths.
interface bsn_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [bsn_pkg::DOM_W-1:0]   domain_number;
  logic [bsn_pkg::BUS_W-1:0]   bus_number;
  logic [bsn_pkg::DEV_W-1:0]   device_number;
  logic [bsn_pkg::FUNC_W-1:0]  function_number;

  modport source (output valid, opcode, domain_number, bus_number, device_number,
                  function_number, input ready);
  modport sink   (input valid, opcode, domain_number, bus_number, device_number,
                  function_number, output ready);
endinterface

FILE: hdl/bsn_rsp_if.sv
// Response channel of the board slot number table: valid, ready and result fields.
// Depends on bsn_pkg for field widths.
interface bsn_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bsn_pkg::STATUS_W-1:0]  status;
  logic [bsn_pkg::CARD_W-1:0]    card_index;

  modport source (output valid, status, card_index, input ready);
  modport sink   (input valid, status, card_index, output ready);
endinterface

FILE: hdl/bsn_cell.sv
// One table entry: key and active-function mask, plus one stage of the request chain.
// Depends on bsn_pkg.
module bsn_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         used_i,
  input  logic [bsn_pkg::CARD_W-1:0]   card_i,
  input  logic                         vld_i,
  input  bsn_pkg::tok_t                tok_i,
  output logic                         vld_o,
  output bsn_pkg::tok_t                tok_o,
  output logic                         alloc_o
);

  logic [bsn_pkg::KEY_W-1:0]  key_q, key_d;
  logic [bsn_pkg::MASK_W-1:0] mask_q, mask_d;
  logic [bsn_pkg::MASK_W-1:0] fbit;
  logic                       vld_q;
  bsn_pkg::tok_t              tok_q, tok_d;

  assign fbit = bsn_pkg::MASK_W'(1) << tok_i.func;

  always_comb begin
    tok_d   = tok_i;
    key_d   = key_q;
    mask_d  = mask_q;
    alloc_o = 1'b0;
    if (vld_i && !tok_i.done) begin
      if (used_i) begin
        if (key_q == tok_i.key) begin
          tok_d.done = 1'b1;
          if (tok_i.opcode == bsn_pkg::OP_ATTACH) begin
            if ((mask_q & fbit) != '0) begin
              tok_d.status = bsn_pkg::ST_BUSY;
            end else begin
              mask_d     = mask_q | fbit;
              tok_d.card = card_i;
            end
          end else begin
            mask_d = mask_q & ~fbit;
          end
        end
      end else if (tok_i.opcode == bsn_pkg::OP_ATTACH) begin
        // first free entry reached without a match: claim it
        key_d      = tok_i.key;
        mask_d     = fbit;
        alloc_o    = 1'b1;
        tok_d.done = 1'b1;
        tok_d.card = card_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    mask_q <= mask_d;
    tok_q  <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

FILE: hdl/board_slot_number_table.sv
// Board slot number table: top level, a row of entry cells with a request chain.
// Depends on bsn_pkg, bsn_req_if, bsn_rsp_if and bsn_cell.
//
// Usage: drive attach (opcode 0) or release (opcode 1) transactions with the
// PCI domain, bus, device and function on req_i; each one returns exactly one
// transaction on rsp_o with a status and, on a successful attach, the board's
// card index (order of first attach, modulo 16).
// The request walks the row of MAX_CARDS cells, one cell per cycle; the cell
// holding the matching key, or the first free cell on a new attach, acts on it.
// The response is registered after the last cell of the chain. One request is in
// flight at a time, and req_i.ready rises only in the cycle after the response
// transaction, so with a ready receiver a new request is taken only once the
// previous response has been taken.
// Reset clears the entry count and the chain; entry contents need no clearing
// since only entries below the count are compared. While the receiver stalls
// the response is held and req_i.ready stays low.
module board_slot_number_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsn_req_if.sink   req_i,
  bsn_rsp_if.source rsp_o
);

  localparam int N = bsn_pkg::MAX_CARDS;

  logic [N:0]                  vld;
  bsn_pkg::tok_t               tok [N+1];
  logic [N-1:0]                alloc;
  logic [N-1:0]                used;
  logic [bsn_pkg::CNT_W-1:0]   entries_used_q;
  logic                        busy_q;
  logic                        res_vld_q;
  bsn_pkg::tok_t               res_q, res_d;
  logic                        in_acc, out_acc;

  assign req_i.ready = !busy_q;
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_acc     = rsp_o.valid && rsp_o.ready;

  assign vld[0]         = in_acc;
  assign tok[0].done    = 1'b0;
  assign tok[0].opcode  = req_i.opcode;
  assign tok[0].key     = {req_i.domain_number, req_i.bus_number, req_i.device_number};
  assign tok[0].func    = req_i.function_number;
  assign tok[0].status  = bsn_pkg::ST_OK;
  assign tok[0].card    = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    assign used[k] = (bsn_pkg::CNT_W'(k) < entries_used_q);
    bsn_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .used_i  (used[k]),
      .card_i  (bsn_pkg::CARD_W'(k)),
      .vld_i   (vld[k]),
      .tok_i   (tok[k]),
      .vld_o   (vld[k+1]),
      .tok_o   (tok[k+1]),
      .alloc_o (alloc[k])
    );
  end

  // No cell took the request: full table on attach, unknown board on release
  always_comb begin
    res_d = tok[N];
    if (!tok[N].done) begin
      res_d.card   = '0;
      res_d.status = (tok[N].opcode == bsn_pkg::OP_ATTACH) ? bsn_pkg::ST_FULL
                                                            : bsn_pkg::ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_used_q <= '0;
      busy_q         <= 1'b0;
      res_vld_q      <= 1'b0;
    end else begin
      if (alloc != '0) begin
        entries_used_q <= entries_used_q + bsn_pkg::CNT_W'(1);
      end
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (out_acc) begin
        busy_q <= 1'b0;
      end
      if (vld[N]) begin
        res_vld_q <= 1'b1;
      end else if (out_acc) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld[N]) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid      = res_vld_q;
  assign rsp_o.status     = res_q.status;
  assign rsp_o.card_index = res_q.card;

  a_one_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(alloc))
    else $error("more than one cell claimed an entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_used_q <= bsn_pkg::CNT_W'(N))
    else $error("entry count beyond table size");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({vld, res_vld_q}))
    else $error("more than one request in flight");

  a_busy_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q || (vld[N:1] != '0)) |-> busy_q)
    else $error("request in flight while not busy");

  a_full_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.status == bsn_pkg::ST_FULL) |-> entries_used_q == bsn_pkg::CNT_W'(N))
    else $error("table full reported with free entries");

endmodule

FILE: tb/tb_board_slot_number_table.sv
// Self-checking testbench for board_slot_number_table: directed and random attach and
// release transactions, with the card index and status predicted per request.
// Depends on bsn_pkg, bsn_req_if, bsn_rsp_if and the board_slot_number_table RTL.
module tb_board_slot_number_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SIZE     = 24;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic                       opcode;
    logic [bsn_pkg::DOM_W-1:0]  domain;
    logic [bsn_pkg::BUS_W-1:0]  bus;
    logic [bsn_pkg::DEV_W-1:0]  device;
    logic [bsn_pkg::FUNC_W-1:0] func;
  } bsn_request_t;

  typedef struct packed {
    bsn_pkg::status_e           status;
    logic [bsn_pkg::CARD_W-1:0] card;
  } slot_result_t;

  class slot_scoreboard;
    logic [bsn_pkg::KEY_W-1:0]  board_key [bsn_pkg::MAX_CARDS];
    logic [bsn_pkg::MASK_W-1:0] func_mask [bsn_pkg::MAX_CARDS];
    int                         boards_used = 0;
    slot_result_t               expected_q [$];
    int                         errors = 0;

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Work out the response of one accepted request and update the table copy.
    function void note_request(bsn_request_t r);
      logic [bsn_pkg::KEY_W-1:0] key;
      int                        hit;
      slot_result_t              res;
      key = {r.domain, r.bus, r.device};
      hit = -1;
      for (int i = 0; i < boards_used; i++) begin
        if (hit < 0 && board_key[i] == key) hit = i;
      end
      res.status = bsn_pkg::ST_OK;
      res.card   = '0;
      if (r.opcode == bsn_pkg::OP_ATTACH) begin
        if (hit >= 0) begin
          if (func_mask[hit][r.func]) begin
            res.status = bsn_pkg::ST_BUSY;
          end else begin
            func_mask[hit][r.func] = 1'b1;
            res.card = bsn_pkg::CARD_W'(hit);
          end
        end else if (boards_used >= bsn_pkg::MAX_CARDS) begin
          res.status = bsn_pkg::ST_FULL;
        end else begin
          board_key[boards_used] = key;
          func_mask[boards_used] = '0;
          func_mask[boards_used][r.func] = 1'b1;
          res.card = bsn_pkg::CARD_W'(boards_used);
          boards_used++;
        end
      end else if (hit >= 0) begin
        func_mask[hit][r.func] = 1'b0;
      end else begin
        res.status = bsn_pkg::ST_UNKNOWN;
      end
      expected_q.push_back(res);
    endfunction

    function void check_response(logic [bsn_pkg::STATUS_W-1:0] status,
                                 logic [bsn_pkg::CARD_W-1:0] card);
      slot_result_t exp_res;
      if (expected_q.size() == 0) begin
        flag($sformatf("%0t: unexpected response status=%0d card=%0d", $realtime,
                       status, card));
        return;
      end
      exp_res = expected_q.pop_front();
      if (status !== exp_res.status)
        flag($sformatf("%0t: status mismatch: expected %s (%0d), got %0d", $realtime,
                       exp_res.status.name(), exp_res.status, status));
      if (card !== exp_res.card)
        flag($sformatf("%0t: card_index mismatch: expected %0d, got %0d", $realtime,
                       exp_res.card, card));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bsn_req_if req_if ();
  bsn_rsp_if rsp_if ();

  board_slot_number_table i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  slot_scoreboard            sb = new();
  logic [bsn_pkg::KEY_W-1:0] board_pool [POOL_SIZE];
  int                        src_idle_pct = 0;
  int                        rcv_idle_pct = 0;
  int                        items_sent   = 0;
  logic                      hold_rsp     = 1'b0;
  int                        idle_cycles;

  always #5ns clk = ~clk;

  // Receiver: check each response transaction, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.status, rsp_if.card_index);
    rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= rcv_idle_pct);
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("board_slot_number_table test failed");
    $finish;
  end

  task automatic send_request(bsn_request_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.opcode          <= r.opcode;
    req_if.domain_number   <= r.domain;
    req_if.bus_number      <= r.bus;
    req_if.device_number   <= r.device;
    req_if.function_number <= r.func;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    sb.note_request(r);
    items_sent++;
  endtask

  task automatic send_board(logic op, int slot, logic [bsn_pkg::FUNC_W-1:0] fn);
    bsn_request_t r;
    r.opcode = op;
    {r.domain, r.bus, r.device} = board_pool[slot];
    r.func = fn;
    send_request(r);
  endtask

  // Hold the sender off until every expected response has come back.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic hold_responses(int cycles);
    hold_rsp <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_rsp <= 1'b0;
  endtask

  // Mostly requests for known boards, the pool widening as the run goes on so the
  // table fills gradually; some fully random noise on top.
  task automatic send_random();
    bsn_request_t r;
    int           limit;
    limit = 6 + items_sent / 20;
    if (limit > POOL_SIZE - 1) limit = POOL_SIZE - 1;
    if ($urandom_range(99) < 10) begin
      r.opcode = ($urandom_range(1) == 0) ? bsn_pkg::OP_ATTACH : bsn_pkg::OP_RELEASE;
      {r.domain, r.bus, r.device, r.func} = $urandom;
    end else begin
      r.opcode = ($urandom_range(99) < 55) ? bsn_pkg::OP_ATTACH : bsn_pkg::OP_RELEASE;
      {r.domain, r.bus, r.device} = board_pool[$urandom_range(limit)];
      r.func = bsn_pkg::FUNC_W'($urandom_range(bsn_pkg::MASK_W - 1));
    end
    send_request(r);
  endtask

  initial begin
    rst_n                  = 1'b0;
    req_if.valid           = 1'b0;
    req_if.opcode          = bsn_pkg::OP_ATTACH;
    req_if.domain_number   = '0;
    req_if.bus_number      = '0;
    req_if.device_number   = '0;
    req_if.function_number = '0;
    rsp_if.ready           = 1'b0;

    // Extreme keys, keys that differ from zero in one field only, and one next to all ones
    board_pool[0] = '0;
    board_pool[1] = '1;
    board_pool[2] = {16'h0000, 8'h00, 5'h01};
    board_pool[3] = {16'h0000, 8'h01, 5'h00};
    board_pool[4] = {16'h0001, 8'h00, 5'h00};
    board_pool[5] = {16'hFFFF, 8'hFF, 5'h1E};
    for (int i = 6; i < POOL_SIZE; i++) board_pool[i] = bsn_pkg::KEY_W'($urandom);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 34;
    rcv_idle_pct = 76;
    send_board(bsn_pkg::OP_RELEASE, 0, 3'd0);  // release on an empty table
    send_board(bsn_pkg::OP_ATTACH,  0, 3'd0);
    send_board(bsn_pkg::OP_ATTACH,  0, 3'd0);  // function already active
    send_board(bsn_pkg::OP_ATTACH,  0, 3'd7);
    send_board(bsn_pkg::OP_ATTACH,  1, 3'd7);
    send_board(bsn_pkg::OP_ATTACH,  2, 3'd3);
    send_board(bsn_pkg::OP_ATTACH,  3, 3'd5);
    send_board(bsn_pkg::OP_ATTACH,  4, 3'd0);
    send_board(bsn_pkg::OP_RELEASE, 0, 3'd7);
    send_board(bsn_pkg::OP_RELEASE, 0, 3'd7);  // release of an inactive function
    send_board(bsn_pkg::OP_ATTACH,  0, 3'd7);
    send_board(bsn_pkg::OP_RELEASE, 1, 3'd0);
    send_board(bsn_pkg::OP_RELEASE, 5, 3'd1);  // unknown board, close to a known one
    send_board(bsn_pkg::OP_ATTACH,  1, 3'd7);
    send_board(bsn_pkg::OP_ATTACH,  2, 3'd3);
    send_board(bsn_pkg::OP_RELEASE, 2, 3'd3);
    send_board(bsn_pkg::OP_ATTACH,  2, 3'd3);
    send_board(bsn_pkg::OP_ATTACH,  5, 3'd2);
    send_board(bsn_pkg::OP_RELEASE, 4, 3'd0);
    send_board(bsn_pkg::OP_ATTACH,  4, 3'd6);
    repeat (280) send_random();
    drain_responses();

    src_idle_pct = 76;
    rcv_idle_pct = 34;
    repeat (140) send_random();
    drain_responses();
    repeat (140) send_random();
    drain_responses();

    src_idle_pct = 0;
    rcv_idle_pct = 0;
    fork
      hold_responses(HOLD_CYCLES);
    join_none
    repeat (290) send_random();
    drain_responses();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("board_slot_number_table test passed");
    end else begin
      $display("board_slot_number_table test failed");
    end
    $finish;
  end

endmodule
